[src/tsc_pkg.sv]
// Package: types, codes and constants of the tunnelling session controller.
`default_nettype none
package tsc_pkg;

   typedef enum logic [3:0] {
      ACT_CONNECT      = 4'd0,
      ACT_CONNRESP     = 4'd1,
      ACT_CONNTIMEOUT  = 4'd2,
      ACT_REQUEST      = 4'd3,
      ACT_ACK          = 4'd4,
      ACT_REQTIMEOUT   = 4'd5,
      ACT_HBRESP       = 4'd6,
      ACT_HBTIMEOUT    = 4'd7,
      ACT_DISC         = 4'd8,
      ACT_DISCTIMEOUT  = 4'd9,
      ACT_DISCRESP     = 4'd10,
      ACT_RX_TUNNEL    = 4'd11,
      ACT_RX_HB        = 4'd12,
      ACT_RX_DISC      = 4'd13,
      ACT_IDLECHECK    = 4'd14,
      ACT_UNKNOWN      = 4'd15
   } action_type;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_BADCONFIG   = 4'd1,
      ST_QUEUEFULL   = 4'd2,
      ST_SHUTDOWN    = 4'd3,
      ST_SEQERR      = 4'd4,
      ST_CONNFAIL    = 4'd5,
      ST_TIMEOUT     = 4'd6,
      ST_HBFAIL      = 4'd7,
      ST_IDLE        = 4'd8,
      ST_MALFORMED   = 4'd9,
      ST_UNSUPPORTED = 4'd10
   } status_type;

   typedef enum logic [2:0] {
      MODE_IDLE       = 3'd0,
      MODE_CONNECTING = 3'd1,
      MODE_CONNECTED  = 3'd2,
      MODE_WAITING    = 3'd3,
      MODE_CLOSING    = 3'd4,
      MODE_CLOSED     = 3'd5
   } mode_type;

   localparam int unsigned CSR_RETRY_LIMIT = 0;
   localparam int unsigned CSR_ACK_WAIT    = 1;
   localparam int unsigned CSR_HB_LIMIT    = 2;
   localparam int unsigned CSR_IDLE_LIMIT  = 3;
   localparam int unsigned CSR_IDX_W       = 2;
   localparam int unsigned CSR_DATA_W      = 32;

   localparam logic [7:0]  RETRY_LIMIT_RST = 8'd3;
   localparam logic [15:0] ACK_WAIT_RST    = 16'd1000;
   localparam logic [7:0]  HB_LIMIT_RST    = 8'd3;
   localparam logic [31:0] IDLE_LIMIT_RST  = 32'd120000;
   localparam logic [7:0]  HB_MAX          = 8'hFF;

   localparam int unsigned FIFO_DEPTH_DEF  = 2;

   typedef struct packed {
      action_type  action;
      logic        bad_action;
      logic [7:0]  channel;
      logic        chan_zero;
      logic [7:0]  seq_in;
      logic        auto_seq;
      logic        fst_err;
      logic        payload_empty;
      logic [15:0] peer_address;
      logic [31:0] time_ms;
   } event_type;

   typedef struct packed {
      status_type  status;
      mode_type    mode;
      logic [7:0]  seq_out;
      logic [7:0]  channel;
      logic [31:0] deadline;
      logic [15:0] address;
   } result_type;

endpackage
`default_nettype wire

[src/tsc_front.sv]
// Front end: accepts and classifies input words, queues them for the engine.
`default_nettype none
module tsc_front
   import tsc_pkg::*;
#(
   parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [3:0]  req_action,
   input  wire logic [7:0]  req_channel,
   input  wire logic [7:0]  req_seq_in,
   input  wire logic        req_auto_seq,
   input  wire logic [7:0]  req_frame_status,
   input  wire logic        req_payload_empty,
   input  wire logic [15:0] req_peer_address,
   input  wire logic [31:0] req_time_ms,
   output logic             evt_valid,
   input  wire logic        evt_take,
   output event_type        evt
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   event_type         mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   event_type         cls;
   logic              do_push, do_pop;

   always_comb begin
      cls.action        = action_type'(req_action);
      cls.bad_action    = (req_action == ACT_UNKNOWN);
      cls.channel       = req_channel;
      cls.chan_zero     = (req_channel == 8'd0);
      cls.seq_in        = req_seq_in;
      cls.auto_seq      = req_auto_seq;
      cls.fst_err       = (req_frame_status != 8'd0);
      cls.payload_empty = req_payload_empty;
      cls.peer_address  = req_peer_address;
      cls.time_ms       = req_time_ms;
   end

   assign full      = (count_ff == CW'(DEPTH));
   assign evt_valid = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = evt_take && evt_valid;
   assign evt       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |=> !(count_ff > CW'(DEPTH)))
      else $error("front queue overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("front queue count did not advance");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (!evt_valid) |-> !do_pop)
      else $error("pop from empty front queue");
`endif
endmodule
`default_nettype wire

[src/tsc_engine.sv]
// Back end: session state machine and result register.
`default_nettype none
module tsc_engine
   import tsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic        evt_valid,
   output logic             evt_take,
   input  wire event_type   evt,
   output logic             res_valid,
   input  wire logic        res_take,
   output result_type       res
);
   logic [7:0]  retry_limit_ff, heartbeat_limit_ff;
   logic [15:0] ack_wait_ff;
   logic [31:0] idle_limit_ff;

   mode_type    mode_ff, mode_in;
   logic        awaiting_ff, awaiting_in;
   logic [7:0]  chan_ff, chan_in, expect_ff, expect_in, next_seq_ff, next_seq_in;
   logic [8:0]  req_tries_ff, req_tries_in, con_tries_ff, con_tries_in;
   logic [8:0]  dis_tries_ff, dis_tries_in;
   logic [7:0]  hb_fail_ff, hb_fail_in;
   logic [31:0] deadline_ff, deadline_in, last_active_ff, last_active_in;
   logic        rx_valid_ff, rx_valid_in;
   logic [7:0]  rx_last_ff, rx_last_in, rx_next_ff, rx_next_in;
   logic [15:0] addr_ff, addr_in;

   logic        res_valid_ff;
   result_type  res_ff;
   status_type  st;
   logic [7:0]  seq_used, s_sel, hb_inc;
   logic        frame, hb_close, step;
   logic [31:0] ddl_grow;

   assign res_valid = res_valid_ff;
   assign res       = res_ff;
   assign evt_take  = evt_valid && (!res_valid_ff || res_take);
   assign step      = evt_take;
   assign ddl_grow  = deadline_ff + {16'd0, ack_wait_ff};
   assign s_sel     = evt.auto_seq ? next_seq_ff : evt.seq_in;
   assign hb_inc    = (hb_fail_ff < HB_MAX) ? hb_fail_ff + 8'd1 : hb_fail_ff;
   assign hb_close  = (heartbeat_limit_ff == 8'd0) || (hb_inc >= heartbeat_limit_ff);

   always_comb begin
      mode_in = mode_ff; awaiting_in = awaiting_ff; chan_in = chan_ff;
      expect_in = expect_ff; next_seq_in = next_seq_ff;
      req_tries_in = req_tries_ff; con_tries_in = con_tries_ff;
      dis_tries_in = dis_tries_ff; hb_fail_in = hb_fail_ff;
      deadline_in = deadline_ff; last_active_in = last_active_ff;
      rx_valid_in = rx_valid_ff; rx_last_in = rx_last_ff; rx_next_in = rx_next_ff;
      addr_in = addr_ff;
      st = ST_OK; seq_used = 8'd0; frame = 1'b0;
      unique case (evt.action)
         ACT_CONNECT: begin
            if (mode_ff != MODE_IDLE) st = ST_BADCONFIG;
            else begin
               mode_in = MODE_CONNECTING; con_tries_in = '0; deadline_in = evt.time_ms;
            end
         end
         ACT_CONNRESP: begin
            frame = 1'b1;
            if (mode_ff != MODE_IDLE && mode_ff != MODE_CONNECTING) st = ST_BADCONFIG;
            else if (evt.fst_err || evt.chan_zero) begin
               if (mode_ff == MODE_CONNECTING) begin
                  mode_in = MODE_IDLE; con_tries_in = '0;
               end
               st = evt.fst_err ? ST_CONNFAIL : ST_SEQERR;
            end else begin
               chan_in = evt.channel; addr_in = evt.peer_address;
               mode_in = MODE_CONNECTED; awaiting_in = 1'b0;
               req_tries_in = '0; con_tries_in = '0; dis_tries_in = '0;
               hb_fail_in = '0; last_active_in = '0; rx_valid_in = 1'b0;
            end
         end
         ACT_CONNTIMEOUT: begin
            if (mode_ff != MODE_CONNECTING) st = ST_BADCONFIG;
            else begin
               con_tries_in = con_tries_ff + 9'd1;
               if (con_tries_in > {1'b0, retry_limit_ff}) begin
                  mode_in = MODE_CLOSED; st = ST_TIMEOUT;
               end else deadline_in = ddl_grow;
            end
         end
         ACT_REQUEST: begin
            if (awaiting_ff) st = ST_QUEUEFULL;
            else if (mode_ff == MODE_CLOSING || mode_ff == MODE_CLOSED) st = ST_SHUTDOWN;
            else if (evt.chan_zero) st = ST_SEQERR;
            else begin
               awaiting_in = 1'b1; mode_in = MODE_WAITING; chan_in = evt.channel;
               expect_in = s_sel; next_seq_in = s_sel + 8'd1;
               deadline_in = evt.time_ms; seq_used = s_sel;
            end
         end
         ACT_ACK: begin
            frame = 1'b1;
            if (evt.fst_err) st = ST_CONNFAIL;
            else if (!awaiting_ff || chan_ff != evt.channel || expect_ff != evt.seq_in)
               st = ST_SEQERR;
            else begin
               awaiting_in = 1'b0; mode_in = MODE_CONNECTED; req_tries_in = '0;
            end
         end
         ACT_REQTIMEOUT: begin
            if (!awaiting_ff) st = ST_BADCONFIG;
            else begin
               req_tries_in = req_tries_ff + 9'd1;
               if (req_tries_in > {1'b0, retry_limit_ff}) begin
                  awaiting_in = 1'b0; mode_in = MODE_CLOSED; st = ST_TIMEOUT;
               end else begin
                  deadline_in = ddl_grow; mode_in = MODE_WAITING;
               end
            end
         end
         ACT_HBRESP: begin
            frame = 1'b1;
            if (mode_ff != MODE_CONNECTED) st = ST_BADCONFIG;
            else if (evt.channel != chan_ff) st = ST_SEQERR;
            else if (evt.fst_err) begin
               hb_fail_in = hb_inc;
               if (hb_close) begin
                  mode_in = MODE_CLOSED; st = ST_HBFAIL;
               end else st = ST_CONNFAIL;
            end else hb_fail_in = '0;
         end
         ACT_HBTIMEOUT: begin
            if (mode_ff != MODE_CONNECTED) st = ST_BADCONFIG;
            else begin
               hb_fail_in = hb_inc;
               if (hb_close) begin
                  mode_in = MODE_CLOSED; st = ST_HBFAIL;
               end else st = ST_CONNFAIL;
            end
         end
         ACT_DISC: begin
            if (mode_ff == MODE_CLOSED) st = ST_SHUTDOWN;
            else if (mode_ff != MODE_CONNECTED) st = ST_BADCONFIG;
            else begin
               mode_in = MODE_CLOSING; dis_tries_in = '0;
            end
         end
         ACT_DISCTIMEOUT: begin
            if (mode_ff != MODE_CLOSING) st = ST_BADCONFIG;
            else begin
               dis_tries_in = dis_tries_ff + 9'd1;
               if (dis_tries_in > {1'b0, retry_limit_ff}) begin
                  mode_in = MODE_CLOSED; st = ST_TIMEOUT;
               end
            end
         end
         ACT_DISCRESP: begin
            frame = 1'b1;
            if (mode_ff == MODE_CLOSED) st = ST_SHUTDOWN;
            else if (mode_ff != MODE_CLOSING) st = ST_BADCONFIG;
            else if (evt.channel != chan_ff) st = ST_SEQERR;
            else if (evt.fst_err) st = ST_CONNFAIL;
            else mode_in = MODE_CLOSED;
         end
         ACT_RX_TUNNEL: begin
            frame = 1'b1;
            if (mode_ff != MODE_CONNECTED) st = ST_BADCONFIG;
            else if (evt.channel != chan_ff) st = ST_SEQERR;
            else if (evt.payload_empty) st = ST_MALFORMED;
            else if (rx_valid_ff && (evt.seq_in == rx_last_ff || evt.seq_in != rx_next_ff))
               st = ST_SEQERR;
            else begin
               rx_valid_in = 1'b1; rx_last_in = evt.seq_in; rx_next_in = evt.seq_in + 8'd1;
            end
         end
         ACT_RX_HB: begin
            frame = 1'b1;
            if (mode_ff != MODE_CONNECTED) st = ST_BADCONFIG;
            else if (evt.channel != chan_ff) st = ST_SEQERR;
         end
         ACT_RX_DISC: begin
            frame = 1'b1;
            if (mode_ff != MODE_CONNECTED && mode_ff != MODE_CLOSING) st = ST_BADCONFIG;
            else if (evt.channel != chan_ff) st = ST_SEQERR;
            else mode_in = MODE_CLOSING;
         end
         ACT_IDLECHECK: begin
            if (mode_ff == MODE_CONNECTED &&
                (evt.time_ms - last_active_ff) >= idle_limit_ff) begin
               mode_in = MODE_CLOSED; awaiting_in = 1'b0; st = ST_IDLE;
            end
         end
         ACT_UNKNOWN: st = ST_UNSUPPORTED;
         default: st = ST_UNSUPPORTED;
      endcase
      if (frame && st == ST_OK) last_active_in = evt.time_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RST; ack_wait_ff <= ACK_WAIT_RST;
         heartbeat_limit_ff <= HB_LIMIT_RST; idle_limit_ff <= IDLE_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IDX_W'(CSR_RETRY_LIMIT): retry_limit_ff     <= csr_wdata[7:0];
            CSR_IDX_W'(CSR_ACK_WAIT):    ack_wait_ff        <= csr_wdata[15:0];
            CSR_IDX_W'(CSR_HB_LIMIT):    heartbeat_limit_ff <= csr_wdata[7:0];
            CSR_IDX_W'(CSR_IDLE_LIMIT):  idle_limit_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE; awaiting_ff <= 1'b0; chan_ff <= '0; expect_ff <= '0;
         next_seq_ff <= '0; req_tries_ff <= '0; con_tries_ff <= '0; dis_tries_ff <= '0;
         hb_fail_ff <= '0; deadline_ff <= '0; last_active_ff <= '0; rx_valid_ff <= 1'b0;
         rx_last_ff <= '0; rx_next_ff <= '0; addr_ff <= '0; res_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            mode_ff <= mode_in; awaiting_ff <= awaiting_in; chan_ff <= chan_in;
            expect_ff <= expect_in; next_seq_ff <= next_seq_in;
            req_tries_ff <= req_tries_in; con_tries_ff <= con_tries_in;
            dis_tries_ff <= dis_tries_in; hb_fail_ff <= hb_fail_in;
            deadline_ff <= deadline_in; last_active_ff <= last_active_in;
            rx_valid_ff <= rx_valid_in; rx_last_ff <= rx_last_in;
            rx_next_ff <= rx_next_in; addr_ff <= addr_in;
         end
         if (step) res_valid_ff <= 1'b1;
         else if (res_take) res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         res_ff.status   <= st;
         res_ff.mode     <= mode_in;
         res_ff.seq_out  <= seq_used;
         res_ff.channel  <= chan_in;
         res_ff.deadline <= deadline_in;
         res_ff.address  <= addr_in;
      end
   end

`ifndef ASSERT_OFF
   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CLOSED) |=> mode_ff == MODE_CLOSED)
      else $error("left closed mode");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && !res_take) |=> res_valid_ff && $stable(res_ff))
      else $error("result dropped while stalled");
   a_wait_awaiting: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_WAITING) |-> awaiting_ff)
      else $error("waiting mode without pending request");
`endif
endmodule
`default_nettype wire

[src/tunnelling_session_controller.sv]
// Top level of the tunnelling session controller.
// A pushed word goes through the input queue and then the result register to the ports.
// Throughput: one event per cycle unless a result waits unpopped, which stalls the engine.
// Input queue holds DEPTH words; the result register frees as it is popped.
// Reset: synchronous, active high; clears session state, queues and loads register defaults.
`default_nettype none
module tunnelling_session_controller
   import tsc_pkg::*;
#(
   parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [3:0]  req_action,
   input  wire logic [7:0]  req_channel,
   input  wire logic [7:0]  req_seq_in,
   input  wire logic        req_auto_seq,
   input  wire logic [7:0]  req_frame_status,
   input  wire logic        req_payload_empty,
   input  wire logic [15:0] req_peer_address,
   input  wire logic [31:0] req_time_ms,
   output logic             empty,
   input  wire logic        pop,
   output logic [3:0]       rsp_status,
   output logic [2:0]       rsp_session_mode,
   output logic [7:0]       rsp_seq_out,
   output logic [7:0]       rsp_channel_out,
   output logic [31:0]      rsp_deadline_out,
   output logic [15:0]      rsp_address_out,
   input  wire logic        csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   logic       evt_valid, evt_take, res_valid;
   event_type  evt;
   result_type res;

   tsc_front #(.DEPTH(DEPTH)) u_front (
      .clock, .reset, .push, .full,
      .req_action, .req_channel, .req_seq_in, .req_auto_seq,
      .req_frame_status, .req_payload_empty, .req_peer_address, .req_time_ms,
      .evt_valid, .evt_take, .evt
   );

   tsc_engine u_engine (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .evt_valid, .evt_take, .evt,
      .res_valid, .res_take(pop), .res
   );

   assign empty            = !res_valid;
   assign rsp_status       = res.status;
   assign rsp_session_mode = res.mode;
   assign rsp_seq_out      = res.seq_out;
   assign rsp_channel_out  = res.channel;
   assign rsp_deadline_out = res.deadline;
   assign rsp_address_out  = res.address;
endmodule
`default_nettype wire
